@@ rtl/core/magnetic_line_follow_steering_top_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the line follower steering block
// Clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef MAGNETIC_LINE_FOLLOW_STEERING_TOP_ASSERT_SVH
`define MAGNETIC_LINE_FOLLOW_STEERING_TOP_ASSERT_SVH

// Same-cycle implication.
`define MLFS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MLFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/mlfs_pkg.sv @@
// ---------------------------------------------------------------------------
// mlfs_pkg
// Types and fixed codes of the magnetic line follower steering block.
// ---------------------------------------------------------------------------
package mlfs_pkg;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_BASE_SPEED = 2'd0,
		REG_STEER_KP   = 2'd1,
		REG_STEER_KD   = 2'd2,
		REG_TURN_PREF  = 2'd3
	} cfg_reg_t;

	// Item kinds
	localparam logic KIND_SENSOR = 1'b0;
	localparam logic KIND_TICK   = 1'b1;

	// Sensor line patterns
	localparam logic [2:0] LINE_NONE   = 3'd0;
	localparam logic [2:0] LINE_ONE    = 3'd2;
	localparam logic [2:0] LINE_FORK_R = 3'd3;
	localparam logic [2:0] LINE_FORK_L = 3'd6;
	localparam logic [2:0] LINE_THREE  = 3'd7;

	// Turn preference codes (3 acts as straight)
	localparam logic [1:0] PREF_LEFT  = 2'd1;
	localparam logic [1:0] PREF_RIGHT = 2'd2;

	// Reset values of the configuration registers
	localparam logic signed [12:0] BASE_SPEED_RST = 13'sd1800;
	localparam logic [11:0]        STEER_KP_RST   = 12'd1008;  // 63.0 in Q8.4
	localparam logic [11:0]        STEER_KD_RST   = 12'd160;   // 10.0 in Q8.4

	// Steering saturation bounds
	localparam logic signed [25:0] STEER_MAX = 26'sd32767;
	localparam logic signed [25:0] STEER_MIN = -26'sd32768;

	typedef logic signed [15:0] dev_t;
	typedef logic signed [12:0] drive_t;

endpackage

@@ rtl/core/magnetic_line_follow_steering_top.sv @@
// ---------------------------------------------------------------------------
// magnetic_line_follow_steering_top
// Magnetic tape line follower with PD steering for a differential drive.
// ---------------------------------------------------------------------------
// Sensor items update the tracked deviation and line code on acceptance and
// give no result. Each tick item gives one drive result, registered in turn in
// the operand, product, steering and output registers. Throughput is one item
// per clock while the output side does not stall: every stage (operands, gain
// products, saturated steering, clamped wheel commands) is a register with its
// own valid bit, and a stage loads whenever it is empty or its successor takes
// its content; with a result stalled in the output register the input accepts
// until the stages fill. Steering is (kp*dev + kd*(dev - prev_dev)) / 16,
// truncated toward zero and saturated to 16 bits; the wheels get base_speed
// -/+ steering, clamped to +-DRIVE_LIMIT, left negated for mounting, and both
// forced to zero while no line is seen. Configuration writes take effect at
// the next edge and are expected only while no tick is in flight.
// ---------------------------------------------------------------------------
module magnetic_line_follow_steering_top
	import mlfs_pkg::*;
#(
	parameter int DRIVE_LIMIT = 3000
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [12:0]        cfg_data,
	// input item channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic [2:0]         line_code,
	input  logic signed [15:0] first_line_pos,
	input  logic signed [15:0] middle_line_pos,
	input  logic signed [15:0] third_line_pos,
	// result item channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [12:0] left_drive,
	output logic signed [12:0] right_drive,
	output logic               line_lost
);

	localparam logic signed [17:0] LIM_POS = 18'(DRIVE_LIMIT);
	localparam logic signed [17:0] LIM_NEG = -18'(DRIVE_LIMIT);

	// Configuration registers
	drive_t      base_speed_q;
	logic [11:0] steer_kp_q;
	logic [11:0] steer_kd_q;
	logic [1:0]  turn_pref_q;

	// Tracking state
	dev_t        tracked_dev_q;
	dev_t        prev_dev_q;
	logic [2:0]  last_code_q;

	logic in_acc, tick_acc, sensor_acc;
	dev_t dev_sel;
	logic pick_left, pick_right;

	// Pipeline valid bits and readiness
	logic v_s1, v_s2, v_s3, out_valid_q;
	logic rdy_s1, rdy_s2, rdy_s3, out_ready;

	// Stage 1: operands snapshot
	dev_t               dev_s1;
	logic signed [16:0] diff_s1;
	logic [11:0]        kp_s1, kd_s1;
	drive_t             base_s1;
	logic               lost_s1;

	// Stage 2: gain products
	logic signed [27:0] prod_p_s2;
	logic signed [28:0] prod_d_s2;
	drive_t             base_s2;
	logic               lost_s2;

	// Stage 3: saturated steering
	dev_t               steer_s3;
	drive_t             base_s3;
	logic               lost_s3;

	// Output register
	drive_t             left_q, right_q;
	logic               lost_q;

	logic signed [16:0] dev_diff;
	logic signed [28:0] mult_p;
	logic signed [29:0] mult_d;
	logic signed [29:0] pd_sum, pd_adj;
	logic signed [25:0] pd_quot;
	dev_t               steer_sat;
	logic signed [17:0] mix_l, mix_r, clamp_l, clamp_r, neg_l;

	// ---------------- handshake ----------------
	assign out_ready = !out_valid_q || !out_stall;
	assign rdy_s3    = !v_s3 || out_ready;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign in_stall  = !rdy_s1;

	assign in_acc     = in_valid && !in_stall;
	assign tick_acc   = in_acc && (kind == KIND_TICK);
	assign sensor_acc = in_acc && (kind == KIND_SENSOR);

	// ---------------- deviation selection ----------------
	assign pick_left  = (turn_pref_q == PREF_LEFT);
	assign pick_right = (turn_pref_q == PREF_RIGHT);

	always_comb begin
		dev_sel = tracked_dev_q;
		unique case (line_code)
			LINE_NONE:   dev_sel = '0;
			LINE_ONE:    dev_sel = middle_line_pos;
			LINE_FORK_L: dev_sel = pick_left ? first_line_pos : middle_line_pos;
			LINE_FORK_R: dev_sel = pick_right ? third_line_pos : middle_line_pos;
			LINE_THREE: begin
				if (pick_left) begin
					dev_sel = third_line_pos;
				end else if (pick_right) begin
					dev_sel = first_line_pos;
				end else begin
					dev_sel = middle_line_pos;
				end
			end
			default:     dev_sel = tracked_dev_q;  // unknown pattern keeps deviation
		endcase
	end

	// ---------------- config and tracking state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_speed_q  <= BASE_SPEED_RST;
			steer_kp_q    <= STEER_KP_RST;
			steer_kd_q    <= STEER_KD_RST;
			turn_pref_q   <= '0;
			tracked_dev_q <= '0;
			prev_dev_q    <= '0;
			last_code_q   <= LINE_NONE;
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_BASE_SPEED: base_speed_q <= cfg_data;
					REG_STEER_KP:   steer_kp_q   <= cfg_data[11:0];
					REG_STEER_KD:   steer_kd_q   <= cfg_data[11:0];
					REG_TURN_PREF:  turn_pref_q  <= cfg_data[1:0];
				endcase
			end
			if (sensor_acc) begin
				last_code_q   <= line_code;
				tracked_dev_q <= dev_sel;
			end
			// previous deviation follows every tick, line lost or not
			if (tick_acc) begin
				prev_dev_q <= tracked_dev_q;
			end
		end
	end

	// ---------------- valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1)    v_s1        <= tick_acc;
			if (rdy_s2)    v_s2        <= v_s1;
			if (rdy_s3)    v_s3        <= v_s2;
			if (out_ready) out_valid_q <= v_s3;
		end
	end

	// ---------------- stage 1: operands ----------------
	assign dev_diff = {tracked_dev_q[15], tracked_dev_q} - {prev_dev_q[15], prev_dev_q};

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			dev_s1  <= tracked_dev_q;
			diff_s1 <= dev_diff;
			kp_s1   <= steer_kp_q;
			kd_s1   <= steer_kd_q;
			base_s1 <= base_speed_q;
			lost_s1 <= (last_code_q == LINE_NONE);
		end
	end

	// ---------------- stage 2: products ----------------
	assign mult_p = $signed({1'b0, kp_s1}) * dev_s1;
	assign mult_d = $signed({1'b0, kd_s1}) * diff_s1;

	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			prod_p_s2 <= mult_p[27:0];  // |kp*dev| < 2^27
			prod_d_s2 <= mult_d[28:0];  // |kd*diff| < 2^28
			base_s2   <= base_s1;
			lost_s2   <= lost_s1;
		end
	end

	// ---------------- stage 3: sum, /16 toward zero, saturate ----------------
	assign pd_sum  = {{2{prod_p_s2[27]}}, prod_p_s2} + {prod_d_s2[28], prod_d_s2};
	assign pd_adj  = pd_sum[29] ? (pd_sum + 30'sd15) : pd_sum;
	assign pd_quot = pd_adj[29:4];

	always_comb begin
		if (pd_quot > STEER_MAX) begin
			steer_sat = STEER_MAX[15:0];
		end else if (pd_quot < STEER_MIN) begin
			steer_sat = STEER_MIN[15:0];
		end else begin
			steer_sat = pd_quot[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && rdy_s3) begin
			steer_s3 <= steer_sat;
			base_s3  <= base_s2;
			lost_s3  <= lost_s2;
		end
	end

	// ---------------- output: mix, clamp, mount sign ----------------
	assign mix_l = {{5{base_s3[12]}}, base_s3} - {{2{steer_s3[15]}}, steer_s3};
	assign mix_r = {{5{base_s3[12]}}, base_s3} + {{2{steer_s3[15]}}, steer_s3};

	always_comb begin
		if (mix_l > LIM_POS) begin
			clamp_l = LIM_POS;
		end else if (mix_l < LIM_NEG) begin
			clamp_l = LIM_NEG;
		end else begin
			clamp_l = mix_l;
		end
		if (mix_r > LIM_POS) begin
			clamp_r = LIM_POS;
		end else if (mix_r < LIM_NEG) begin
			clamp_r = LIM_NEG;
		end else begin
			clamp_r = mix_r;
		end
	end

	assign neg_l = -clamp_l;

	always_ff @(posedge clk) begin
		if (v_s3 && out_ready) begin
			left_q  <= lost_s3 ? '0 : neg_l[12:0];
			right_q <= lost_s3 ? '0 : clamp_r[12:0];
			lost_q  <= lost_s3;
		end
	end

	assign out_valid   = out_valid_q;
	assign left_drive  = left_q;
	assign right_drive = right_q;
	assign line_lost   = lost_q;

endmodule

@@ rtl/core/mlfs_checker.sv @@
// ---------------------------------------------------------------------------
// mlfs_checker
// Port-level checks of the line follower steering block, bound to the top.
// ---------------------------------------------------------------------------
`include "magnetic_line_follow_steering_top_assert.svh"

module mlfs_checker #(
	parameter int DRIVE_LIMIT = 3000
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [12:0] left_drive,
	input logic signed [12:0] right_drive,
	input logic               line_lost
);

	// lost line means both wheels stopped
	`MLFS_ASSERT_NOW(a_lost_stops, out_valid && line_lost, (left_drive == 13'sd0) && (right_drive == 13'sd0), "drive nonzero with line lost")

	// commands stay in range when the limit fits the field
	`MLFS_ASSERT_NOW(a_drive_range, out_valid && (DRIVE_LIMIT <= 4095), (left_drive <= DRIVE_LIMIT) && (left_drive >= -DRIVE_LIMIT) && (right_drive <= DRIVE_LIMIT) && (right_drive >= -DRIVE_LIMIT), "drive beyond limit")

	// a free output register lets the whole pipe move
	`MLFS_ASSERT_NOW(a_no_false_stall, !out_valid || !out_stall, !in_stall, "input stalled with output free")

	// a stalled result holds
	`MLFS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(left_drive) && $stable(right_drive) && $stable(line_lost), "stalled item changed")

endmodule

bind magnetic_line_follow_steering_top mlfs_checker #(
	.DRIVE_LIMIT(DRIVE_LIMIT)
) u_mlfs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.left_drive (left_drive),
	.right_drive(right_drive),
	.line_lost  (line_lost)
);
